// ----- hdl/pll_pkg.sv -----
package pll_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int POS_W    = 8;
  // compare width: wide enough for position and count + 1
  localparam int CMP_W    = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_END   = 3'd1,
    OP_INS_POS   = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_END   = 3'd4,
    OP_DEL_POS   = 3'd5,
    OP_READ_OUT  = 3'd6,
    OP_NOP       = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef struct packed {
    op_t                     opcode;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
  } in_item_t;

  typedef struct packed {
    status_t                 status;
    logic signed [VAL_W-1:0] element;
    logic                    last;
  } out_item_t;

  // link held by an entry that has never been written: the next entry, wrapping
  function automatic logic [IDX_W-1:0] link_reset(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] res;
    if (idx == IDX_W'(CAPACITY - 1)) begin
      res = '0;
    end else begin
      res = idx + 1'b1;
    end
    return res;
  endfunction

endpackage

// ----- hdl/pll_ram.sv -----
module pll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/positional_linked_list_top.sv -----
// Channel | Direction | Handshake             | Payload
// in_     | input     | in_valid / in_stall   | pll_pkg::in_item_t  (opcode, value, position)
// out_    | output    | out_valid / out_stall | pll_pkg::out_item_t (status, element, last)
//
// One transaction at a time. Errors and the no-op go from S_IDLE straight to S_RESP,
// front operations through S_TAKE or S_DEL_FRONT; positional operations, insert and
// delete at the end and readout walk the link memory one link a cycle through its single
// read port. Readout gives one result per element, one per cycle while out_stall is low.
// Synchronous active-low reset; the link memory's reset chain comes from per-entry
// valid bits, so no clearing pass is needed. A result waits in the output register
// while the next item is taken; out_stall only pauses the block when a new result
// must be loaded into an occupied output register.
module positional_linked_list_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pll_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pll_pkg::out_item_t   out_data
);
  import pll_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE       = 11'b000_0000_0001,
    S_TAKE       = 11'b000_0000_0010,
    S_WALK       = 11'b000_0000_0100,
    S_INS_LINK   = 11'b000_0000_1000,
    S_INS_PREV   = 11'b000_0001_0000,
    S_DEL_VICT   = 11'b000_0010_0000,
    S_DEL_RELINK = 11'b000_0100_0000,
    S_DEL_FREE   = 11'b000_1000_0000,
    S_DEL_FRONT  = 11'b001_0000_0000,
    S_RO         = 11'b010_0000_0000,
    S_RESP       = 11'b100_0000_0000
  } state_t;

  // control state
  state_t               state_r,  state_nxt;
  logic [IDX_W-1:0]     first_r,  first_nxt;
  logic [IDX_W-1:0]     free_r,   free_nxt;
  logic [CNT_W-1:0]     count_r,  count_nxt;
  logic [CAPACITY-1:0]  lvalid_r;
  logic                 out_valid_r;

  // per-transaction working registers
  logic                 is_ins_r, is_ins_nxt;
  logic                 p1_r,     p1_nxt;
  logic [VAL_W-1:0]     value_r,  value_nxt;
  logic [CNT_W-1:0]     steps_r,  steps_nxt;
  logic [CNT_W-1:0]     rem_r,    rem_nxt;
  logic [IDX_W-1:0]     cur_r,    cur_nxt;
  logic                 pend_r,   pend_nxt;
  logic [IDX_W-1:0]     prev_r,   prev_nxt;
  logic [IDX_W-1:0]     node_r,   node_nxt;
  status_t              status_r, status_nxt;
  logic                 lv_q_r;
  logic [IDX_W-1:0]     raddr_q_r;
  out_item_t            out_data_r;

  // memory ports
  logic                 re;
  logic [IDX_W-1:0]     raddr;
  logic                 lwe;
  logic [IDX_W-1:0]     lwaddr;
  logic [IDX_W-1:0]     lwdata;
  logic                 vwe;
  logic [IDX_W-1:0]     vwaddr;
  logic [VAL_W-1:0]     vwdata;
  logic [IDX_W-1:0]     link_rdata;
  logic [VAL_W-1:0]     val_rdata;

  logic [IDX_W-1:0]     link_eff;
  logic [IDX_W-1:0]     cur_now;
  logic                 out_free;
  logic                 out_load;
  out_item_t            out_nxt;

  // position decode at accept
  logic [CMP_W-1:0]     pos_c, cnt_c, p_c;
  logic                 ins_bad, del_bad, full, empty;

  pll_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_link_ram (
    .clk   (clk),
    .we    (lwe),
    .waddr (lwaddr),
    .wdata (lwdata),
    .re    (re),
    .raddr (raddr),
    .rdata (link_rdata)
  );

  pll_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_value_ram (
    .clk   (clk),
    .we    (vwe),
    .waddr (vwaddr),
    .wdata (vwdata),
    .re    (re),
    .raddr (raddr),
    .rdata (val_rdata)
  );

  // entries never written hold the reset chain
  assign link_eff = lv_q_r ? link_rdata : link_reset(raddr_q_r);
  // walk position: fresh link data if a step is in flight
  assign cur_now  = pend_r ? link_eff : cur_r;

  assign pos_c   = CMP_W'(in_data.position);
  assign cnt_c   = CMP_W'(count_r);
  assign full    = (count_r == CNT_W'(CAPACITY));
  assign empty   = (count_r == '0);
  assign ins_bad = (in_data.position == '0) || (pos_c > cnt_c + CMP_W'(1));
  assign del_bad = (in_data.position == '0) || (pos_c > cnt_c);

  always_comb begin
    unique case (in_data.opcode)
      OP_INS_FRONT, OP_DEL_FRONT: p_c = CMP_W'(1);
      OP_INS_END:                 p_c = cnt_c + CMP_W'(1);
      OP_DEL_END:                 p_c = cnt_c;
      default:                    p_c = pos_c;
    endcase
  end

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    first_nxt  = first_r;
    free_nxt   = free_r;
    count_nxt  = count_r;
    is_ins_nxt = is_ins_r;
    p1_nxt     = p1_r;
    value_nxt  = value_r;
    steps_nxt  = steps_r;
    rem_nxt    = rem_r;
    cur_nxt    = cur_r;
    pend_nxt   = pend_r;
    prev_nxt   = prev_r;
    node_nxt   = node_r;
    status_nxt = status_r;
    re         = 1'b0;
    raddr      = cur_now;
    lwe        = 1'b0;
    lwaddr     = node_r;
    lwdata     = free_r;
    vwe        = 1'b0;
    vwaddr     = free_r;
    vwdata     = value_r;
    out_load   = 1'b0;
    out_nxt    = '{status: status_r, element: '0, last: 1'b1};

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          is_ins_nxt = (in_data.opcode == OP_INS_FRONT) || (in_data.opcode == OP_INS_END) ||
                       (in_data.opcode == OP_INS_POS);
          value_nxt  = in_data.value;
          p1_nxt     = (p_c == CMP_W'(1));
          steps_nxt  = CNT_W'(p_c - CMP_W'(2));
          rem_nxt    = count_r;
          cur_nxt    = first_r;
          pend_nxt   = 1'b0;
          status_nxt = ST_OK;
          unique case (in_data.opcode)
            OP_INS_FRONT, OP_INS_END, OP_INS_POS: begin
              priority if (full) begin
                status_nxt = ST_FULL;
                state_nxt  = S_RESP;
              end else if ((in_data.opcode == OP_INS_POS) && ins_bad) begin
                status_nxt = ST_BADPOS;
                state_nxt  = S_RESP;
              end else begin
                re        = 1'b1;
                raddr     = free_r;
                state_nxt = S_TAKE;
              end
            end
            OP_DEL_FRONT, OP_DEL_END, OP_DEL_POS: begin
              priority if (empty) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_RESP;
              end else if ((in_data.opcode == OP_DEL_POS) && del_bad) begin
                status_nxt = ST_BADPOS;
                state_nxt  = S_RESP;
              end else if (p_c == CMP_W'(1)) begin
                re        = 1'b1;
                raddr     = first_r;
                state_nxt = S_DEL_FRONT;
              end else begin
                state_nxt = S_WALK;
              end
            end
            OP_READ_OUT: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_RESP;
              end else begin
                re        = 1'b1;
                raddr     = first_r;
                state_nxt = S_RO;
              end
            end
            OP_NOP: begin
              state_nxt = S_RESP;
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end

      S_TAKE: begin
        // pop the free chain head and fill its value
        node_nxt = free_r;
        free_nxt = link_eff;
        vwe      = 1'b1;
        vwaddr   = free_r;
        vwdata   = value_r;
        if (p1_r) begin
          lwe       = 1'b1;
          lwaddr    = free_r;
          lwdata    = first_r;
          first_nxt = free_r;
          count_nxt = count_r + 1'b1;
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_WALK;
        end
      end

      S_WALK: begin
        re    = 1'b1;
        raddr = cur_now;
        if (steps_r == '0) begin
          prev_nxt  = cur_now;
          pend_nxt  = 1'b0;
          state_nxt = is_ins_r ? S_INS_LINK : S_DEL_VICT;
        end else begin
          cur_nxt   = cur_now;
          steps_nxt = steps_r - 1'b1;
          pend_nxt  = 1'b1;
        end
      end

      S_INS_LINK: begin
        lwe       = 1'b1;
        lwaddr    = node_r;
        lwdata    = link_eff;
        state_nxt = S_INS_PREV;
      end

      S_INS_PREV: begin
        lwe       = 1'b1;
        lwaddr    = prev_r;
        lwdata    = node_r;
        count_nxt = count_r + 1'b1;
        state_nxt = S_RESP;
      end

      S_DEL_VICT: begin
        node_nxt  = link_eff;
        re        = 1'b1;
        raddr     = link_eff;
        state_nxt = S_DEL_RELINK;
      end

      S_DEL_RELINK: begin
        lwe       = 1'b1;
        lwaddr    = prev_r;
        lwdata    = link_eff;
        state_nxt = S_DEL_FREE;
      end

      S_DEL_FREE: begin
        lwe       = 1'b1;
        lwaddr    = node_r;
        lwdata    = free_r;
        free_nxt  = node_r;
        count_nxt = count_r - 1'b1;
        state_nxt = S_RESP;
      end

      S_DEL_FRONT: begin
        lwe       = 1'b1;
        lwaddr    = first_r;
        lwdata    = free_r;
        free_nxt  = first_r;
        first_nxt = link_eff;
        count_nxt = count_r - 1'b1;
        state_nxt = S_RESP;
      end

      S_RO: begin
        // read data holds in the RAM output until the next read is issued
        if (out_free) begin
          out_load = 1'b1;
          out_nxt  = '{status: ST_OK, element: val_rdata, last: (rem_r == CNT_W'(1))};
          rem_nxt  = rem_r - 1'b1;
          if (rem_r == CNT_W'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            re    = 1'b1;
            raddr = link_eff;
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      first_r     <= '0;
      free_r      <= '0;
      count_r     <= '0;
      lvalid_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      first_r <= first_nxt;
      free_r  <= free_nxt;
      count_r <= count_nxt;
      if (lwe) begin
        lvalid_r[lwaddr] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    is_ins_r <= is_ins_nxt;
    p1_r     <= p1_nxt;
    value_r  <= value_nxt;
    steps_r  <= steps_nxt;
    rem_r    <= rem_nxt;
    cur_r    <= cur_nxt;
    pend_r   <= pend_nxt;
    prev_r   <= prev_nxt;
    node_r   <= node_nxt;
    status_r <= status_nxt;
    if (re) begin
      lv_q_r    <= lvalid_r[raddr];
      raddr_q_r <= raddr;
    end
    if (out_load) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- hdl/pll_checker.sv -----
module pll_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input pll_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input pll_pkg::out_item_t out_data
);
  import pll_pkg::*;

  // nothing left in the output register after reset
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // a stalled input transaction stays offered and unchanged
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input changed");

  // taking a transaction makes the sequencer busy and raises in_stall
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("new transaction taken with no busy cycle");

  // any non-ok status is a lone result with no element
  a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_OK) |-> out_data.last && (out_data.element == '0))
    else $error("error status with element or without last");

endmodule

bind positional_linked_list_top pll_checker u_pll_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
